### rtl/shfp_pkg.sv
package shfp_pkg;

  typedef longint unsigned u64_t;

  localparam int BLOCK     = 1024;
  localparam int LOG_BLOCK = $clog2(BLOCK);
  localparam int HALF      = BLOCK / 2;
  localparam int DW        = 33;
  localparam int TWW       = 17;
  localparam int RAD_W     = 2 * DW;
  localparam int ROOT_W    = DW;

  localparam logic [1:0] CFG_CHUNK = 2'd0;
  localparam logic [1:0] CFG_RATE  = 2'd1;
  localparam logic [1:0] CFG_MINF  = 2'd2;
  localparam logic [1:0] CFG_MAXF  = 2'd3;

  localparam u64_t ONE_Q30     = 64'd1073741824;
  localparam u64_t PI_HALF_Q30 = 64'd1686629713;

  typedef logic [15:0] hann_tab_t [BLOCK];
  typedef logic signed [TWW-1:0] tw_tab_t [HALF];

  // cosine of u quarter turns, q30
  function automatic longint cos_quarter(u64_t u);
    u64_t x;
    u64_t x2;
    u64_t term;
    longint s;
    x = (u * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    s = longint'(ONE_Q30);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1: term = term / 64'd2;
        2: term = term / 64'd12;
        3: term = term / 64'd30;
        4: term = term / 64'd56;
        5: term = term / 64'd90;
        6: term = term / 64'd132;
        7: term = term / 64'd182;
        default: term = term / 64'd240;
      endcase
      if (k % 2 == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) s = 0;
    if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
    return s;
  endfunction

  function automatic longint cos_turn(logic [31:0] phase);
    u64_t r;
    longint c;
    r = {34'd0, phase[29:0]};
    case (phase[31:30])
      2'd0: c = cos_quarter(r);
      2'd1: c = -cos_quarter(ONE_Q30 - r);
      2'd2: c = -cos_quarter(r);
      default: c = cos_quarter(ONE_Q30 - r);
    endcase
    return c;
  endfunction

  function automatic hann_tab_t make_hann();
    hann_tab_t t;
    u64_t ph;
    longint w;
    for (int i = 0; i < BLOCK; i++) begin
      ph = (u64_t'(i) << 32) / (BLOCK - 1);
      w = (longint'(ONE_Q30) - cos_turn(ph[31:0]) + 16384) >>> 15;
      t[i] = (w > 65535) ? 16'hFFFF : w[15:0];
    end
    return t;
  endfunction

  function automatic tw_tab_t make_tw(logic sine);
    tw_tab_t t;
    u64_t ph;
    logic [31:0] p;
    longint v;
    for (int i = 0; i < HALF; i++) begin
      ph = (u64_t'(i) << 32) / BLOCK;
      p = sine ? (ph[31:0] - 32'h4000_0000) : ph[31:0];
      v = ((cos_turn(p) + longint'(ONE_Q30) + 16384) >>> 15) - 32768;
      t[i] = v[TWW-1:0];
    end
    return t;
  endfunction

  function automatic logic [LOG_BLOCK-1:0] bit_rev(logic [LOG_BLOCK-1:0] v);
    logic [LOG_BLOCK-1:0] r;
    for (int b = 0; b < LOG_BLOCK; b++) begin
      r[LOG_BLOCK-1-b] = v[b];
    end
    return r;
  endfunction

  localparam hann_tab_t HANN_TAB = make_hann();
  localparam tw_tab_t   TWC_TAB  = make_tw(1'b0);
  localparam tw_tab_t   TWS_TAB  = make_tw(1'b1);

endpackage

### rtl/shfp_ram.sv
module shfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/shfp_sqrt.sv
module shfp_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [shfp_pkg::RAD_W-1:0]   radicand,
  output logic                         done,
  output logic [shfp_pkg::ROOT_W-1:0]  root
);

  localparam int RW = shfp_pkg::ROOT_W + 3;

  logic [shfp_pkg::RAD_W-1:0]  rad_r;
  logic [RW-1:0]               rem_r;
  logic [shfp_pkg::ROOT_W-1:0] root_r;
  logic [5:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [RW-1:0]               sh;
  logic [RW-1:0]               trial;
  logic                        ge;

  assign sh    = {rem_r[RW-3:0], rad_r[shfp_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 6'(shfp_pkg::ROOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= ge ? (sh - trial) : sh;
        root_r <= {root_r[shfp_pkg::ROOT_W-2:0], ge};
        cnt_r  <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/sliding_hann_fft_peak_finder_unit.sv
// an item that completes no chunk is taken and gives no result
// an item that completes a chunk starts a spectrum pass: the two
// 1024-point ffts (butterfly states S_BF0 to S_BF5, one butterfly unit on one work memory)
// plus a magnitude search over the bins in the search range per channel (serial square root)
// the next item is taken once the pass ends; the result waits in the output register
// reset clears the windows to zero through a fill count, no clearing pass
module sliding_hann_fft_peak_finder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_left_sample,
  input  logic signed [15:0] in_right_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_left_peak_bin,
  output logic [16:0]        out_left_peak_freq,
  output logic [15:0]        out_left_peak_mag,
  output logic [9:0]         out_right_peak_bin,
  output logic [16:0]        out_right_peak_freq,
  output logic [15:0]        out_right_peak_mag
);

  localparam int AW = shfp_pkg::LOG_BLOCK;
  localparam int DW = shfp_pkg::DW;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIV  = 5'd1;
  localparam logic [4:0] S_DVE  = 5'd2;
  localparam logic [4:0] S_LD   = 5'd3;
  localparam logic [4:0] S_BF0  = 5'd4;
  localparam logic [4:0] S_BF1  = 5'd5;
  localparam logic [4:0] S_BF2  = 5'd6;
  localparam logic [4:0] S_BF3  = 5'd7;
  localparam logic [4:0] S_BF4  = 5'd8;
  localparam logic [4:0] S_BF5  = 5'd9;
  localparam logic [4:0] S_M0   = 5'd10;
  localparam logic [4:0] S_M1   = 5'd11;
  localparam logic [4:0] S_M2   = 5'd12;
  localparam logic [4:0] S_M3   = 5'd13;
  localparam logic [4:0] S_M4   = 5'd14;
  localparam logic [4:0] S_M5   = 5'd15;
  localparam logic [4:0] S_M6   = 5'd16;
  localparam logic [4:0] S_M7   = 5'd17;
  localparam logic [4:0] S_FCH  = 5'd18;
  localparam logic [4:0] S_OUT  = 5'd19;

  logic [4:0]  state_r;
  logic [10:0] chunk_size_r;
  logic [17:0] sample_rate_r;
  logic [16:0] min_freq_r;
  logic [16:0] max_freq_r;
  logic [AW-1:0] wp_r;
  logic [AW:0]   fill_r;
  logic [10:0] cnt_r;

  logic [26:0] dvd0_r, dvd1_r;
  logic [18:0] rem0_r, rem1_r;
  logic [4:0]  it_r;
  logic [9:0]  start_r, end_r;
  logic        ch_r;

  logic [AW:0]   i_r;
  logic          ld_v1_r, ld_v2_r;
  logic [AW-1:0] ld_i1_r, ld_i2_r;
  logic [15:0]   hann_r;
  logic signed [DW-1:0] prod_r;

  logic [3:0] s_r;
  logic [AW-2:0] b_r;
  logic signed [16:0] cos_r, sin_r;
  logic signed [DW-1:0] a_re_r, a_im_r;
  logic signed [49:0] m0_r, m1_r, m2_r, m3_r;
  logic signed [34:0] pr_r, pi_r;
  logic [2*DW-1:0] nc_r;

  logic [9:0]  k_r;
  logic [DW-1:0] ur_r, ui_r;
  logic [2*DW-1:0] sqr_r, sqi_r, sum_r;
  logic [33:0] nsum_r;
  logic [19:0] e_r;
  logic        found_r;
  logic [9:0]  best_r;
  logic [15:0] bm_r;
  logic [9:0]  lbin_r;
  logic [15:0] lmag_r;

  logic        out_valid_r;
  logic [9:0]  olb_r, orb_r;
  logic [16:0] olf_r, orf_r;
  logic [15:0] olm_r, orm_r;

  logic        accept;
  logic [10:0] lim;
  logic [10:0] cnt_inc;
  logic [18:0] sh0, sh1;
  logic        ge0, ge1;
  logic [31:0] win_rd;
  logic [AW-1:0] win_raddr;
  logic        issue;
  logic [AW:0] vsum;
  logic signed [15:0] xs;
  logic [AW-1:0] mask, bx, jx, a_addr, c_addr, tw_sh;
  logic [AW-2:0] tw_idx;
  logic [2*DW-1:0] work_rd, work_wd;
  logic [AW-1:0] work_raddr, work_waddr;
  logic        work_we;
  logic signed [DW-1:0] c_re, c_im, rd_re, rd_im;
  logic signed [50:0] sum_pr, sum_pi;
  logic signed [50:0] shr_pr, shr_pi;
  logic signed [35:0] sa_re, sa_im, sc_re, sc_im;
  logic signed [35:0] ha_re, ha_im, hc_re, hc_im;
  logic        sq_done;
  logic [DW-1:0] sq_root;
  logic [34:0] e_sum;
  logic [34:0] mrem;
  logic [20:0] q;
  logic [15:0] mag;
  logic [27:0] lfreq, rfreq;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign lim     = (chunk_size_r == 11'd0) ? 11'd1 : chunk_size_r;
  assign cnt_inc = cnt_r + 11'd1;

  assign sh0 = {rem0_r[17:0], dvd0_r[26]};
  assign sh1 = {rem1_r[17:0], dvd1_r[26]};
  assign ge0 = sh0 >= {1'b0, sample_rate_r};
  assign ge1 = sh1 >= {1'b0, sample_rate_r};

  assign issue     = !i_r[AW];
  assign win_raddr = wp_r + i_r[AW-1:0];
  assign vsum      = {1'b0, ld_i1_r} + fill_r;
  assign xs        = ch_r ? $signed(win_rd[31:16]) : $signed(win_rd[15:0]);

  assign mask   = (AW'(1) << s_r) - AW'(1);
  assign bx     = {1'b0, b_r};
  assign jx     = bx & mask;
  assign a_addr = ((bx & ~mask) << 1) | jx;
  assign c_addr = a_addr | (AW'(1) << s_r);
  assign tw_sh  = jx << (4'(AW - 1) - s_r);
  assign tw_idx = tw_sh[AW-2:0];

  assign rd_re = $signed(work_rd[2*DW-1:DW]);
  assign rd_im = $signed(work_rd[DW-1:0]);
  assign c_re  = rd_re;
  assign c_im  = rd_im;

  assign sum_pr = {m0_r[49], m0_r} + {m1_r[49], m1_r} + 51'sd16384;
  assign sum_pi = {m2_r[49], m2_r} - {m3_r[49], m3_r} + 51'sd16384;
  assign shr_pr = sum_pr >>> 15;
  assign shr_pi = sum_pi >>> 15;

  assign sa_re = {{3{a_re_r[DW-1]}}, a_re_r} + {pr_r[34], pr_r} + 36'sd1;
  assign sa_im = {{3{a_im_r[DW-1]}}, a_im_r} + {pi_r[34], pi_r} + 36'sd1;
  assign sc_re = {{3{a_re_r[DW-1]}}, a_re_r} - {pr_r[34], pr_r} + 36'sd1;
  assign sc_im = {{3{a_im_r[DW-1]}}, a_im_r} - {pi_r[34], pi_r} + 36'sd1;
  assign ha_re = sa_re >>> 1;
  assign ha_im = sa_im >>> 1;
  assign hc_re = sc_re >>> 1;
  assign hc_im = sc_im >>> 1;

  assign e_sum = {1'b0, nsum_r} + {16'd0, nsum_r[33:15]} + {31'd0, nsum_r[33:30]};
  assign mrem  = {1'b0, nsum_r} + {15'd0, e_r} - {e_r, 15'd0};
  assign q     = (mrem >= 35'd32767) ? ({1'b0, e_r} + 21'd1) : {1'b0, e_r};
  assign mag   = (q > 21'd65535) ? 16'hFFFF : q[15:0];

  assign lfreq = lbin_r * sample_rate_r;
  assign rfreq = best_r * sample_rate_r;

  always_comb begin
    work_raddr = {1'b0, k_r[AW-2:0]};
    case (state_r)
      S_BF0:   work_raddr = a_addr;
      S_BF1:   work_raddr = c_addr;
      default: work_raddr = {1'b0, k_r[AW-2:0]};
    endcase
  end

  always_comb begin
    work_we    = 1'b0;
    work_waddr = shfp_pkg::bit_rev(ld_i2_r);
    work_wd    = {prod_r, {DW{1'b0}}};
    case (state_r)
      S_LD: begin
        work_we = ld_v2_r;
      end
      S_BF4: begin
        work_we    = 1'b1;
        work_waddr = a_addr;
        work_wd    = {ha_re[DW-1:0], ha_im[DW-1:0]};
      end
      S_BF5: begin
        work_we    = 1'b1;
        work_waddr = c_addr;
        work_wd    = nc_r;
      end
      default: work_we = 1'b0;
    endcase
  end

  shfp_ram #(.WIDTH(32), .DEPTH(shfp_pkg::BLOCK)) u_win_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata ({in_right_sample, in_left_sample}),
    .raddr (win_raddr),
    .rdata (win_rd)
  );

  shfp_ram #(.WIDTH(2 * DW), .DEPTH(shfp_pkg::BLOCK)) u_work_ram (
    .clk   (clk),
    .we    (work_we),
    .waddr (work_waddr),
    .wdata (work_wd),
    .raddr (work_raddr),
    .rdata (work_rd)
  );

  shfp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_M4),
    .radicand (sum_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    hann_r <= shfp_pkg::HANN_TAB[i_r[AW-1:0]];
    cos_r  <= shfp_pkg::TWC_TAB[tw_idx];
    sin_r  <= shfp_pkg::TWS_TAB[tw_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      chunk_size_r  <= 11'd256;
      sample_rate_r <= 18'd48000;
      min_freq_r    <= 17'd0;
      max_freq_r    <= 17'd24000;
      wp_r          <= '0;
      fill_r        <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      ld_v1_r       <= 1'b0;
      ld_v2_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          shfp_pkg::CFG_CHUNK: chunk_size_r  <= cfg_data[10:0];
          shfp_pkg::CFG_RATE:  sample_rate_r <= cfg_data;
          shfp_pkg::CFG_MINF:  min_freq_r    <= cfg_data[16:0];
          shfp_pkg::CFG_MAXF:  max_freq_r    <= cfg_data[16:0];
          default:             chunk_size_r  <= chunk_size_r;
        endcase
      end

      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            wp_r <= wp_r + AW'(1);
            if (!fill_r[AW]) begin
              fill_r <= fill_r + (AW+1)'(1);
            end
            if (cnt_inc >= lim) begin
              cnt_r   <= '0;
              dvd0_r  <= {min_freq_r, 10'd0};
              dvd1_r  <= {max_freq_r, 10'd0};
              rem0_r  <= '0;
              rem1_r  <= '0;
              it_r    <= 5'd27;
              state_r <= S_DIV;
            end else begin
              cnt_r <= cnt_inc;
            end
          end
        end
        S_DIV: begin
          rem0_r <= ge0 ? (sh0 - {1'b0, sample_rate_r}) : sh0;
          rem1_r <= ge1 ? (sh1 - {1'b0, sample_rate_r}) : sh1;
          dvd0_r <= {dvd0_r[25:0], ge0};
          dvd1_r <= {dvd1_r[25:0], ge1};
          it_r   <= it_r - 5'd1;
          if (it_r == 5'd1) begin
            state_r <= S_DVE;
          end
        end
        S_DVE: begin
          start_r <= (sample_rate_r == 18'd0 || dvd0_r > 27'd512) ? 10'd512 : dvd0_r[9:0];
          end_r   <= (sample_rate_r == 18'd0 || dvd1_r > 27'd512) ? 10'd512 : dvd1_r[9:0];
          ch_r    <= 1'b0;
          i_r     <= '0;
          ld_v1_r <= 1'b0;
          ld_v2_r <= 1'b0;
          state_r <= S_LD;
        end
        S_LD: begin
          ld_v1_r <= issue;
          ld_i1_r <= i_r[AW-1:0];
          if (issue) begin
            i_r <= i_r + (AW+1)'(1);
          end
          ld_v2_r <= ld_v1_r;
          ld_i2_r <= ld_i1_r;
          prod_r  <= (vsum[AW] ? xs : 16'sd0) * $signed({1'b0, hann_r});
          if (!issue && !ld_v1_r && !ld_v2_r) begin
            s_r     <= '0;
            b_r     <= '0;
            state_r <= S_BF0;
          end
        end
        S_BF0: state_r <= S_BF1;
        S_BF1: begin
          a_re_r  <= rd_re;
          a_im_r  <= rd_im;
          state_r <= S_BF2;
        end
        S_BF2: begin
          m0_r    <= c_re * cos_r;
          m1_r    <= c_im * sin_r;
          m2_r    <= c_im * cos_r;
          m3_r    <= c_re * sin_r;
          state_r <= S_BF3;
        end
        S_BF3: begin
          pr_r    <= shr_pr[34:0];
          pi_r    <= shr_pi[34:0];
          state_r <= S_BF4;
        end
        S_BF4: begin
          nc_r    <= {hc_re[DW-1:0], hc_im[DW-1:0]};
          state_r <= S_BF5;
        end
        S_BF5: begin
          state_r <= S_BF0;
          if (b_r == {(AW-1){1'b1}}) begin
            b_r <= '0;
            if (s_r == 4'(AW - 1)) begin
              k_r     <= start_r;
              found_r <= 1'b0;
              best_r  <= end_r;
              bm_r    <= '0;
              state_r <= S_M0;
            end else begin
              s_r <= s_r + 4'd1;
            end
          end else begin
            b_r <= b_r + (AW-1)'(1);
          end
        end
        S_M0: begin
          state_r <= (k_r >= end_r) ? S_FCH : S_M1;
        end
        S_M1: begin
          ur_r    <= rd_re[DW-1] ? (~work_rd[2*DW-1:DW] + DW'(1)) : work_rd[2*DW-1:DW];
          ui_r    <= rd_im[DW-1] ? (~work_rd[DW-1:0] + DW'(1)) : work_rd[DW-1:0];
          state_r <= S_M2;
        end
        S_M2: begin
          sqr_r   <= ur_r * ur_r;
          sqi_r   <= ui_r * ui_r;
          state_r <= S_M3;
        end
        S_M3: begin
          sum_r   <= sqr_r + sqi_r;
          state_r <= S_M4;
        end
        S_M4: state_r <= S_M5;
        S_M5: begin
          if (sq_done) begin
            nsum_r  <= {1'b0, sq_root} + 34'd16383;
            state_r <= S_M6;
          end
        end
        S_M6: begin
          e_r     <= e_sum[34:15];
          state_r <= S_M7;
        end
        S_M7: begin
          if (!found_r || mag > bm_r) begin
            found_r <= 1'b1;
            best_r  <= k_r;
            bm_r    <= mag;
          end
          k_r     <= k_r + 10'd1;
          state_r <= S_M0;
        end
        S_FCH: begin
          if (!ch_r) begin
            lbin_r  <= best_r;
            lmag_r  <= bm_r;
            ch_r    <= 1'b1;
            i_r     <= '0;
            ld_v1_r <= 1'b0;
            ld_v2_r <= 1'b0;
            state_r <= S_LD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            olb_r   <= lbin_r;
            olf_r   <= lfreq[26:10];
            olm_r   <= lmag_r;
            orb_r   <= best_r;
            orf_r   <= rfreq[26:10];
            orm_r   <= bm_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_peak_bin   = olb_r;
  assign out_left_peak_freq  = olf_r;
  assign out_left_peak_mag   = olm_r;
  assign out_right_peak_bin  = orb_r;
  assign out_right_peak_freq = orf_r;
  assign out_right_peak_mag  = orm_r;

endmodule
